@@ hw/rtl/rbd_pkg.sv @@
// Shared types and constants for the ring buffer deque.
package rbd_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam int KIND_W  = 2;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;
    localparam int OUT_RAW = WORD_W + STAT_W + OCC_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

endpackage

@@ hw/rtl/ring_buffer_deque.sv @@
// Top level of the ring buffer deque: controller plus datapath.
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+--------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tuser: kind, tdata: value
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata: value_res, status, occupancy
//
// Each operation passes from transfer in to result valid and back to ready through
// capture, store access, registered store read and result hold.
// One operation is in flight at a time; s_axis_tready is low until the result transfers.
// A stalled m_axis holds the result and blocks the next transfer in.
// Synchronous reset empties the deque (head and count zero); store contents stay undefined.
module ring_buffer_deque
    import rbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic [KIND_W-1:0] s_axis_tuser,   // [1:0] kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // [31:0] value_res, [33:32] status,
                                              // [38:34] occupancy, [39] zero
);

    t_cmd cmd;

    rbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_cmd      (cmd)
    );

    rbd_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_kind  (s_axis_tuser),
        .i_value (s_axis_tdata),
        .o_result(m_axis_tdata)
    );

endmodule

@@ hw/rtl/rbd_ram.sv @@
// Generic single-port RAM with registered read.
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rbd_ctrl.sv @@
// Control state machine sequencing one deque operation at a time.
module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOAD = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/rbd_dp.sv @@
// Datapath: head and count registers, store access and result register.
module rbd_dp
    import rbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [WORD_W-1:0] i_value,
    output logic [OUT_W-1:0]  o_result
);

    logic [KIND_W-1:0] r_kind;
    logic [WORD_W-1:0] r_value;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  n_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic              r_take;
    logic              n_take;
    logic [WORD_W-1:0] r_res;
    logic [STAT_W-1:0] r_res_status;
    logic [OCC_W-1:0]  r_occ;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    logic [WORD_W-1:0] mem_rdata;
    logic [IDX_W-1:0]  head_dec;
    logic [IDX_W-1:0]  head_inc;
    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  tail_idx;
    logic              is_full;
    logic              is_empty;

    assign head_dec = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_count) - 1'b1;
    assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : tail_sum[IDX_W-1:0];
    assign is_full  = (r_count >= CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = STAT_OK;
        n_take   = 1'b0;
        mem_we   = 1'b0;
        mem_addr = r_head;
        case (r_kind)
            KIND_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = STAT_FULL;
                end else begin
                    mem_we   = i_cmd.exec;
                    mem_addr = head_dec;
                    n_head   = head_dec;
                    n_count  = r_count + 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                if (is_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_take  = 1'b1;
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (is_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_take   = 1'b1;
                    mem_addr = tail_idx;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    rbd_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(r_value),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_take   <= n_take;
        end
        if (i_cmd.load) begin
            r_res        <= r_take ? mem_rdata : '0;
            r_res_status <= r_status;
            r_occ        <= OCC_W'(r_count);
        end
    end

    assign o_result = OUT_W'({r_occ, r_res_status, r_res});

endmodule

@@ tb/deque_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the ring buffer deque: tracks the deque contents and compares every result.
module deque_checker
    import rbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    input  logic              i_s_axis_tready,
    input  logic [WORD_W-1:0] i_s_axis_tdata,   // [31:0] value
    input  logic [KIND_W-1:0] i_s_axis_tuser,   // [1:0] kind
    input  logic              i_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    input  logic [OUT_W-1:0]  i_m_axis_tdata,   // [31:0] value_res, [33:32] status,
                                                // [38:34] occupancy, [39] zero
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [OCC_W-1:0]  occupancy;
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] word;
    } t_deque_result;

    logic [WORD_W-1:0] deque_words [DEPTH];
    logic [IDX_W-1:0]  deque_head;
    logic [CNT_W-1:0]  deque_count;
    t_deque_result     expected_results [$];
    int                fail_count;

    function automatic t_deque_result deque_apply(input logic [KIND_W-1:0] kind,
                                                  input logic [WORD_W-1:0] value);
        t_deque_result res;
        int            tail;
        res = '0;
        res.status = STAT_OK;
        case (kind)
            KIND_PUSH_FRONT: begin
                if (deque_count == DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    deque_head = (deque_head == 0) ? IDX_W'(DEPTH - 1) : deque_head - 1'b1;
                    deque_words[deque_head] = value;
                    deque_count = deque_count + 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                if (deque_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.word = deque_words[deque_head];
                    deque_head = (deque_head == DEPTH - 1) ? '0 : deque_head + 1'b1;
                    deque_count = deque_count - 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (deque_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    tail = (int'(deque_head) + int'(deque_count) - 1) % DEPTH;
                    res.word = deque_words[tail];
                    deque_count = deque_count - 1'b1;
                end
            end
            default: ;
        endcase
        res.occupancy = OCC_W'(deque_count);
        return res;
    endfunction

    initial begin
        fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_deque_result got;
        t_deque_result want;
        if (!i_rst_n) begin
            deque_head = '0;
            deque_count = '0;
            expected_results.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_results.push_back(deque_apply(i_s_axis_tuser, i_s_axis_tdata));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_deque_result'(i_m_axis_tdata[OUT_RAW-1:0]);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word=%h status=%0d occupancy=%0d",
                             $time, got.word, got.status, got.occupancy);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.word !== want.word || got.status !== want.status ||
                        got.occupancy !== want.occupancy) begin
                        $display("%0t: mismatch expected word=%h status=%0d occupancy=%0d",
                                 $time, want.word, want.status, want.occupancy);
                        $display("%0t:          actual   word=%h status=%0d occupancy=%0d",
                                 $time, got.word, got.status, got.occupancy);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count = fail_count;
        o_pending = expected_results.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the ring buffer deque testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
    import rbd_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 100;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam int MODE_PUSH_HEAVY = 0;
    localparam int MODE_POP_HEAVY  = 1;
    localparam int MODE_BALANCED   = 2;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata;
    logic [KIND_W-1:0] s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int stall_left;
    bit idle_en;
    bit long_hold_req;

    ring_buffer_deque u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    deque_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return $urandom;
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input int mode);
        int roll;
        int push_pct;
        roll = $urandom_range(0, 99);
        if (roll < 2) return KIND_UNUSED;
        case (mode)
            MODE_PUSH_HEAVY: push_pct = 72;
            MODE_POP_HEAVY:  push_pct = 30;
            default:         push_pct = 51;
        endcase
        if ($urandom_range(0, 99) < push_pct) return KIND_PUSH_FRONT;
        return ($urandom_range(0, 1) == 0) ? KIND_POP_FRONT : KIND_POP_BACK;
    endfunction

    // receiver side
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        m_axis_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        idle_en       = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_PUSH_FRONT;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pops, unused kind, head wrap both ways
        send_op(KIND_POP_FRONT, 32'hFFFF_FFFF);
        send_op(KIND_POP_BACK, 32'hFFFF_FFFF);
        send_op(KIND_UNUSED, 32'h1234_5678);
        send_op(KIND_PUSH_FRONT, 32'hDEAD_BEEF);
        send_op(KIND_POP_FRONT, '0);

        // fill, overflow, unused kind, then pop once from each end
        send_op(KIND_PUSH_FRONT, 32'h0000_0000);
        send_op(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(KIND_PUSH_FRONT, 32'hAAAA_AAAA);
        send_op(KIND_PUSH_FRONT, 32'h5555_5555);
        for (int i = 4; i < DEPTH; i++) send_op(KIND_PUSH_FRONT, $urandom);
        send_op(KIND_PUSH_FRONT, 32'hCAFE_F00D);
        send_op(KIND_UNUSED, '1);
        send_op(KIND_POP_BACK, '0);
        send_op(KIND_POP_FRONT, '0);

        for (int p = 0; p < PHASES; p++) begin
            idle_en = !(p == 2 || p == 4 || p == PHASES - 1);
            if (p == 4) long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_op(pick_kind(p % 3), pick_word());
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
